### rtl/core/tsd_pkg.sv
// shared types and constants for the textured span draw core
`default_nettype none
package tsd_pkg;

    localparam int SCREEN_WIDTH_DEF = 320;
    localparam int LIGHT_MAPS_DEF   = 64;
    localparam int FLAT_SIDE        = 64;
    localparam int FLAT_AW          = 12;
    localparam int FRAC_BITS        = 16;
    localparam int TEX_BITS         = 6;
    localparam int MAP_ENTRIES      = 256;
    localparam int PX_W             = 10;
    localparam int OFF_W            = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [1:0] FUNC_DRAW      = 2'd0;
    localparam logic [1:0] FUNC_LOAD_FLAT = 2'd1;
    localparam logic [1:0] FUNC_LOAD_MAP  = 2'd2;

    localparam logic CFG_WINDOW_LEFT = 1'b0;
    localparam logic CFG_WINDOW_TOP  = 1'b1;

    typedef enum logic [1:0] {
        CMD_DRAW      = 2'd0,
        CMD_LOAD_FLAT = 2'd1,
        CMD_LOAD_MAP  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         row;
        logic [8:0]         col_first;
        logic [8:0]         col_last;
        logic signed [31:0] u_start;
        logic signed [31:0] v_start;
        logic signed [31:0] u_step;
        logic signed [31:0] v_step;
        logic [5:0]         light_map;
        logic               low_detail;
        logic [11:0]        table_index;
        logic [7:0]         table_byte;
    } item_t;

    typedef struct packed {
        logic [12:0] word_address;
        logic [63:0] pixels;
        logic [7:0]  byte_enable;
        logic        last;
    } result_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [OFF_W-1:0] off0;
        logic [PX_W-1:0]  count;
        logic             low;
        logic [5:0]       map;
        logic             map_ok;
        logic [31:0]      u;
        logic [31:0]      v;
        logic [31:0]      du;
        logic [31:0]      dv;
        logic [11:0]      table_index;
        logic [7:0]       table_byte;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

### rtl/core/tsd_front.sv
// front end: window registers, item decode and span setup
`default_nettype none
module tsd_front #(
    parameter int SCREEN_WIDTH = tsd_pkg::SCREEN_WIDTH_DEF,
    parameter int LIGHT_MAPS   = tsd_pkg::LIGHT_MAPS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_valid,
    input  wire                    cfg_index,
    input  wire [8:0]              cfg_data,
    input  wire                    item_valid,
    input  tsd_pkg::item_t         item,
    output logic                   item_stall,
    input  tsd_pkg::queue_status_t qstat,
    output logic                   push,
    output tsd_pkg::cmd_t          cmd
);

    localparam logic [tsd_pkg::PX_W-1:0] SW_LAST = tsd_pkg::PX_W'(SCREEN_WIDTH - 1);

    logic [8:0] win_left_reg;
    logic [7:0] win_top_reg;

    logic [tsd_pkg::PX_W-1:0]  px0;
    logic [tsd_pkg::PX_W-1:0]  px1;
    logic [tsd_pkg::PX_W-1:0]  px1_clamped;
    logic [8:0]                row_sum;
    logic [tsd_pkg::OFF_W-1:0] base;
    logic                      map_ok;
    logic                      keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg <= 9'd0;
            win_top_reg  <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tsd_pkg::CFG_WINDOW_LEFT: win_left_reg <= cfg_data;
                tsd_pkg::CFG_WINDOW_TOP:  win_top_reg  <= cfg_data[7:0];
                default:                  win_left_reg <= win_left_reg;
            endcase
        end
    end

    always_comb
    begin
        px0 = item.low_detail ? {item.col_first, 1'b0} : {1'b0, item.col_first};
        px1 = item.low_detail ? {item.col_last, 1'b1} : {1'b0, item.col_last};
        px1_clamped = (px1 > SW_LAST) ? SW_LAST : px1;
        row_sum = {1'b0, win_top_reg} + {1'b0, item.row};
        // offsets only matter modulo the word address range, 16 bits carries it
        base = tsd_pkg::OFF_W'(32'(row_sum) * 32'(SCREEN_WIDTH))
             + tsd_pkg::OFF_W'(win_left_reg);
        map_ok = (32'(item.light_map) < 32'(LIGHT_MAPS));

        cmd.kind        = tsd_pkg::CMD_DRAW;
        cmd.off0        = base + tsd_pkg::OFF_W'(px0);
        cmd.count       = px1_clamped - px0;
        cmd.low         = item.low_detail;
        cmd.map         = item.light_map;
        cmd.map_ok      = map_ok;
        cmd.u           = item.u_start;
        cmd.v           = item.v_start;
        cmd.du          = item.u_step;
        cmd.dv          = item.v_step;
        cmd.table_index = item.table_index;
        cmd.table_byte  = item.table_byte;

        unique case (item.func)
            tsd_pkg::FUNC_DRAW:
            begin
                keep = (item.col_last >= item.col_first) && (px0 <= SW_LAST);
            end
            tsd_pkg::FUNC_LOAD_FLAT:
            begin
                keep     = 1'b1;
                cmd.kind = tsd_pkg::CMD_LOAD_FLAT;
            end
            tsd_pkg::FUNC_LOAD_MAP:
            begin
                keep     = map_ok;
                cmd.kind = tsd_pkg::CMD_LOAD_MAP;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign item_stall = qstat.full;
    assign push       = item_valid && !qstat.full && keep;

endmodule
`default_nettype wire

### rtl/core/tsd_queue.sv
// short command queue between front end and span engine
`default_nettype none
module tsd_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  tsd_pkg::cmd_t          push_cmd,
    input  wire                    pop,
    output tsd_pkg::cmd_t          head,
    output tsd_pkg::queue_status_t qstat
);

    localparam int PTR_W = $clog2(tsd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tsd_pkg::QUEUE_DEPTH + 1);

    tsd_pkg::cmd_t    entry_reg [tsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == tsd_pkg::QUEUE_DEPTH - 1) ? '0
                            : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == tsd_pkg::QUEUE_DEPTH - 1) ? '0
                            : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (32'(count_reg) == tsd_pkg::QUEUE_DEPTH);
    assign qstat.empty = (count_reg == '0);

endmodule
`default_nettype wire

### rtl/core/tsd_back.sv
// span engine: table loads, pixel walk, texel and colormap lookup, word packing
`default_nettype none
module tsd_back #(
    parameter int LIGHT_MAPS = tsd_pkg::LIGHT_MAPS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  tsd_pkg::cmd_t          head,
    input  tsd_pkg::queue_status_t qstat,
    output logic                   pop,
    output logic                   result_valid,
    input  wire                    result_stall,
    output tsd_pkg::result_t       result
);

    localparam int LT_DEPTH = LIGHT_MAPS * tsd_pkg::MAP_ENTRIES;
    localparam int LT_AW    = $clog2(LT_DEPTH);
    localparam int FLAT_DEPTH = tsd_pkg::FLAT_SIDE * tsd_pkg::FLAT_SIDE;
    localparam int U_LO = tsd_pkg::FRAC_BITS;
    localparam int U_HI = tsd_pkg::FRAC_BITS + tsd_pkg::TEX_BITS - 1;

    logic [7:0] flat_mem [FLAT_DEPTH];
    logic [7:0] lt_mem   [LT_DEPTH];

    logic adv;
    logic start_draw;
    logic flat_we;
    logic map_we;

    // walker
    logic                      active_reg;
    logic                      active_next;
    logic [31:0]               u_reg;
    logic [31:0]               v_reg;
    logic [31:0]               du_reg;
    logic [31:0]               dv_reg;
    logic [tsd_pkg::OFF_W-1:0] off_reg;
    logic [tsd_pkg::PX_W-1:0]  cnt_reg;
    logic                      low_reg;
    logic                      phase_reg;
    logic [5:0]                map_reg;
    logic                      map_ok_reg;
    logic [tsd_pkg::FLAT_AW-1:0] flat_rd_addr;

    // texel stage
    logic                      a_valid_reg;
    logic [tsd_pkg::OFF_W-1:0] a_off_reg;
    logic                      a_end_reg;
    logic                      a_last_reg;
    logic [5:0]                a_map_reg;
    logic                      a_map_ok_reg;
    logic [7:0]                texel_reg;
    logic [LT_AW-1:0]          lt_rd_addr;
    logic [LT_AW-1:0]          lt_wr_addr;

    // colormap stage
    logic                      b_valid_reg;
    logic [tsd_pkg::OFF_W-1:0] b_off_reg;
    logic                      b_end_reg;
    logic                      b_last_reg;
    logic                      b_map_ok_reg;
    logic [7:0]                color_raw_reg;

    // packer and output
    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic [7:0]       be_reg;
    logic [7:0]       be_next;
    logic [63:0]      acc_new;
    logic [7:0]       be_new;
    logic [7:0]       color;
    logic             emit;
    logic             out_valid_reg;
    logic             out_valid_next;
    tsd_pkg::result_t out_reg;

    // the whole engine freezes while a finished word waits
    assign adv        = !out_valid_reg || !result_stall;
    assign pop        = adv && !active_reg && !qstat.empty;
    assign start_draw = pop && (head.kind == tsd_pkg::CMD_DRAW);
    assign flat_we    = pop && (head.kind == tsd_pkg::CMD_LOAD_FLAT);
    assign map_we     = pop && (head.kind == tsd_pkg::CMD_LOAD_MAP);

    assign flat_rd_addr = {v_reg[U_HI:U_LO], u_reg[U_HI:U_LO]};
    assign lt_rd_addr   = LT_AW'({24'(a_map_reg), texel_reg});
    assign lt_wr_addr   = LT_AW'({24'(head.map), head.table_index[7:0]});

    always_comb
    begin
        active_next = active_reg;
        if (adv)
        begin
            if (start_draw)
            begin
                active_next = 1'b1;
            end
            else if (active_reg && (cnt_reg == '0))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        color   = b_map_ok_reg ? color_raw_reg : 8'd0;
        acc_new = acc_reg;
        be_new  = be_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (b_off_reg[2:0] == 3'(i))
            begin
                acc_new[i*8 +: 8] = color;
                be_new[i]         = 1'b1;
            end
        end
        emit           = adv && b_valid_reg && b_end_reg;
        acc_next       = acc_reg;
        be_next        = be_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = emit;
            if (b_valid_reg)
            begin
                acc_next = b_end_reg ? 64'd0 : acc_new;
                be_next  = b_end_reg ? 8'd0 : be_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 64'd0;
            be_reg        <= 8'd0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            be_reg        <= be_next;
            if (adv)
            begin
                a_valid_reg <= active_reg;
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // walker payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (start_draw)
            begin
                u_reg      <= head.u;
                v_reg      <= head.v;
                du_reg     <= head.du;
                dv_reg     <= head.dv;
                off_reg    <= head.off0;
                cnt_reg    <= head.count;
                low_reg    <= head.low;
                phase_reg  <= 1'b0;
                map_reg    <= head.map;
                map_ok_reg <= head.map_ok;
            end
            else if (active_reg)
            begin
                off_reg   <= off_reg + tsd_pkg::OFF_W'(1);
                cnt_reg   <= cnt_reg - tsd_pkg::PX_W'(1);
                phase_reg <= !phase_reg;
                // low detail steps the coordinates once per pixel pair
                if (!low_reg || phase_reg)
                begin
                    u_reg <= u_reg + du_reg;
                    v_reg <= v_reg + dv_reg;
                end
            end
        end
    end

    // flat texel store, one port
    always_ff @(posedge clk)
    begin
        if (flat_we)
        begin
            flat_mem[head.table_index] <= head.table_byte;
        end
        else if (adv)
        begin
            texel_reg <= flat_mem[flat_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_off_reg    <= off_reg;
            a_end_reg    <= (off_reg[2:0] == 3'd7) || (cnt_reg == '0);
            a_last_reg   <= (cnt_reg == '0);
            a_map_reg    <= map_reg;
            a_map_ok_reg <= map_ok_reg;
        end
    end

    // colormap store, one write and one read port
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            lt_mem[lt_wr_addr] <= head.table_byte;
        end
        if (adv)
        begin
            color_raw_reg <= lt_mem[lt_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_off_reg    <= a_off_reg;
            b_end_reg    <= a_end_reg;
            b_last_reg   <= a_last_reg;
            b_map_ok_reg <= a_map_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.word_address <= b_off_reg[tsd_pkg::OFF_W-1:3];
            out_reg.pixels       <= acc_new;
            out_reg.byte_enable  <= be_new;
            out_reg.last         <= b_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

### rtl/core/textured_span_draw_core.sv
// top level of the textured span draw core
// path: with the queue and span engine idle, a draw goes through the queue entry, walker,
// texel, colormap and output registers; a word goes out with the pixel that closes it
// throughput: one pixel per cycle unless the output stalls, via the single-port texel
// store and the colormap store; the next item is popped only once the walker is idle
// items queue four deep ahead of the span engine, so the input runs ahead of it
// reset clears control and window registers; table contents are undefined until loaded
`default_nettype none
module textured_span_draw_core #(
    parameter int SCREEN_WIDTH = tsd_pkg::SCREEN_WIDTH_DEF,
    parameter int LIGHT_MAPS   = tsd_pkg::LIGHT_MAPS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_valid,
    output logic             cfg_ready,
    input  wire              cfg_index,
    input  wire [8:0]        cfg_data,
    input  wire              item_valid,
    output logic             item_stall,
    input  tsd_pkg::item_t   item,
    output logic             result_valid,
    input  wire              result_stall,
    output tsd_pkg::result_t result
);

    tsd_pkg::queue_status_t qstat;
    tsd_pkg::cmd_t          push_cmd;
    tsd_pkg::cmd_t          head;
    logic                   push;
    logic                   pop;

    assign cfg_ready = 1'b1;

    tsd_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .LIGHT_MAPS   (LIGHT_MAPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .qstat      (qstat),
        .push       (push),
        .cmd        (push_cmd)
    );

    tsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    tsd_back #(
        .LIGHT_MAPS (LIGHT_MAPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // every word written carries at least one pixel
    a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.byte_enable != 8'h00))
        else $error("word with no byte enabled");

    // a word is closed early only at the end of its span
    a_word_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> result.byte_enable[7])
        else $error("word closed before its last byte");

    // nothing is pulled from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
